// ===== hdl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg: shared definitions for the periodic timer table
// Operation and result codes, field widths, default sizes and the control
// struct that the sequencer broadcasts to the row of timer cells.
// ----------------------------------------------------------------------------
package ptt_pkg;

   // field widths of the request and response beats
   localparam int OP_W   = 2;
   localparam int IVL_W  = 16;
   localparam int SLOT_W = 3;
   localparam int KIND_W = 3;

   // default sizing
   localparam int NUM_SLOTS_DEF  = 8;
   localparam int COUNT_BITS_DEF = 16;

   // request operations
   localparam logic [OP_W-1:0] OP_SET       = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR     = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK      = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL = 2'd3;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_SET_OK     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_NO_SPACE   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FIRED      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_CLEAR_DONE = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TICK_DONE  = 3'd4;

   // controls shared by every cell in the row
   typedef struct packed {
      logic scan_set;   // walking token looks for a free slot
      logic scan_tick;  // walking token advances each active countdown
      logic clear_all;  // drop every slot
   } ptt_bcast_type;

endpackage

// ===== hdl/periodic_timer_table_core.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_table_core: table of periodic timer slots
// A row of timer cells walked by a scan token. Set claims the lowest free
// slot, clear frees one or all slots, tick advances every active countdown
// and reports each expiring slot in ascending order.
//
//   channel   ports                                    handshake
//   request   req_op, req_interval, req_slot           start & !busy
//   response  rsp_kind, rsp_slot_index, rsp_last       rsp_strobe, 1 cycle
//
// Clear and clear-all: busy never rises; the response beat is registered
// and appears in the cycle after acceptance. Tick: busy until the token
// has left the row. Set: busy until a slot is claimed, or until the token
// leaves a full table. The token moves one cell per cycle along the row.
// Reset clears all slots and the sequencer. The response side cannot stall.
// ----------------------------------------------------------------------------
module periodic_timer_table_core
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [OP_W-1:0]   req_op,
   input  logic [IVL_W-1:0]  req_interval,
   input  logic [SLOT_W-1:0] req_slot,
   output logic              rsp_strobe,
   output logic [KIND_W-1:0] rsp_kind,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic              rsp_last
);

   ptt_bcast_type         bcast;
   logic                  launch;
   logic [NUM_SLOTS-1:0]  clear_vec;
   logic [COUNT_BITS-1:0] ivl;
   logic [NUM_SLOTS:0]    tok_chain;
   logic [NUM_SLOTS-1:0]  hit_vec;
   logic                  cell_hit;

   ptt_ctrl #(
      .NUM_SLOTS  (NUM_SLOTS),
      .COUNT_BITS (COUNT_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_op         (req_op),
      .req_interval   (req_interval),
      .req_slot       (req_slot),
      .rsp_strobe     (rsp_strobe),
      .rsp_kind       (rsp_kind),
      .rsp_slot_index (rsp_slot_index),
      .rsp_last       (rsp_last),
      .bcast          (bcast),
      .launch         (launch),
      .clear_vec      (clear_vec),
      .ivl            (ivl),
      .cell_hit       (cell_hit)
   );

   // token enters the row at slot zero
   assign tok_chain[0] = launch;

   // row of slot cells
   for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
      ptt_cell #(
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .bcast   (bcast),
         .tok_i   (tok_chain[g]),
         .tok_o   (tok_chain[g+1]),
         .clear_i (clear_vec[g]),
         .ivl_i   (ivl),
         .hit_o   (hit_vec[g])
      );
   end

   assign cell_hit = |hit_vec;

`ifndef SYNTH
   // at most one cell acts on the token per cycle
   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell hit in a cycle");

   // a fire beat never closes its request
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_kind == KIND_FIRED) |-> !rsp_last)
      else $error("fire beat marked last");

   // a closing beat arrives only after the sequencer went idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |-> $past(busy) || !busy || $past(start))
      else $error("last beat while scan still running");

   // accepted clear answers in the next cycle
   a_clear_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_op == OP_CLEAR || req_op == OP_CLEAR_ALL))
      |=> (rsp_strobe && rsp_kind == KIND_CLEAR_DONE && rsp_last))
      else $error("clear not answered");

   // no token lives in the row while idle
   a_idle_no_tok: assert property (@(posedge clock) disable iff (reset)
      (!busy && !$past(busy)) |-> !cell_hit)
      else $error("cell hit while idle");
`endif

endmodule

// ===== hdl/ptt_cell.sv =====
// ----------------------------------------------------------------------------
// ptt_cell: one timer slot
// Holds the active flag, period and countdown of a slot. A scan token
// enters from the lower neighbor into the token register, is acted on there
// and moves on to the upper neighbor; a claiming cell swallows the token.
// ----------------------------------------------------------------------------
module ptt_cell
   import ptt_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ptt_bcast_type         bcast,
   input  logic                  tok_i,
   output logic                  tok_o,
   input  logic                  clear_i,
   input  logic [COUNT_BITS-1:0] ivl_i,
   output logic                  hit_o
);

   logic                  tok_ff;
   logic                  active_ff, active_in;
   logic [COUNT_BITS-1:0] period_ff, period_in;
   logic [COUNT_BITS-1:0] remain_ff, remain_in;
   logic                  claim;
   logic                  fire;
   logic                  step;

   // token actions in this cell
   assign claim = tok_ff & bcast.scan_set & ~active_ff;
   assign step  = tok_ff & bcast.scan_tick & active_ff;
   assign fire  = step & (remain_ff == '0);
   assign hit_o = claim | fire;
   assign tok_o = tok_ff & ~claim;

   // slot state update
   always_comb begin
      active_in = active_ff;
      period_in = period_ff;
      remain_in = remain_ff;
      if (bcast.clear_all || clear_i) begin
         active_in = 1'b0;
      end else if (claim) begin
         active_in = 1'b1;
         period_in = ivl_i;
         remain_in = ivl_i - COUNT_BITS'(1);
      end else if (step) begin
         remain_in = fire ? (period_ff - COUNT_BITS'(1)) : (remain_ff - COUNT_BITS'(1));
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= 1'b0;
         active_ff <= 1'b0;
      end else begin
         tok_ff    <= tok_i;
         active_ff <= active_in;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      remain_ff <= remain_in;
   end

endmodule

// ===== hdl/ptt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptt_ctrl: request sequencer and response register
// Takes request beats, launches the scan token into the cell row, follows
// the token position with a counter and registers at most one response beat
// per cycle.
// ----------------------------------------------------------------------------
module ptt_ctrl
   import ptt_pkg::*;
#(
   parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_op,
   input  logic [IVL_W-1:0]      req_interval,
   input  logic [SLOT_W-1:0]     req_slot,
   output logic                  rsp_strobe,
   output logic [KIND_W-1:0]     rsp_kind,
   output logic [SLOT_W-1:0]     rsp_slot_index,
   output logic                  rsp_last,
   output ptt_bcast_type         bcast,
   output logic                  launch,
   output logic [NUM_SLOTS-1:0]  clear_vec,
   output logic [COUNT_BITS-1:0] ivl,
   input  logic                  cell_hit
);

   localparam int IDX_W = $clog2(NUM_SLOTS + 1);

   // sequencer states
   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic                  state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  set_ff, set_in;
   logic [COUNT_BITS-1:0] ivl_ff, ivl_in;
   logic                  strobe_ff, strobe_in;
   logic [KIND_W-1:0]     kind_ff, kind_in;
   logic [SLOT_W-1:0]     sidx_ff, sidx_in;
   logic                  last_ff, last_in;
   logic                  accept;
   logic                  end_step;
   logic [COUNT_BITS-1:0] ivl_mask;

   assign busy     = (state_ff == ST_SCAN);
   assign accept   = start & ~busy;
   assign end_step = (idx_ff == IDX_W'(NUM_SLOTS));
   assign ivl_mask = COUNT_BITS'(req_interval);
   assign ivl      = ivl_ff;

   // broadcast controls
   assign launch          = accept & ((req_op == OP_SET) | (req_op == OP_TICK));
   assign bcast.scan_set  = busy & set_ff;
   assign bcast.scan_tick = busy & ~set_ff;
   assign bcast.clear_all = accept & (req_op == OP_CLEAR_ALL);

   // single-slot clear decode, slots beyond the field range never match
   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         clear_vec[i] = accept && (req_op == OP_CLEAR) && (i < (1 << SLOT_W))
                        && (req_slot == SLOT_W'(i));
      end
   end

   // sequencing and response selection
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      set_in    = set_ff;
      ivl_in    = ivl_ff;
      strobe_in = 1'b0;
      kind_in   = kind_ff;
      sidx_in   = sidx_ff;
      last_in   = last_ff;
      if (state_ff == ST_IDLE) begin
         if (accept) begin
            case (req_op)
               OP_SET, OP_TICK: begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
                  set_in   = (req_op == OP_SET);
                  ivl_in   = (ivl_mask == '0) ? COUNT_BITS'(1) : ivl_mask;
               end
               OP_CLEAR: begin
                  strobe_in = 1'b1;
                  kind_in   = KIND_CLEAR_DONE;
                  sidx_in   = req_slot;
                  last_in   = 1'b1;
               end
               default: begin
                  strobe_in = 1'b1;
                  kind_in   = KIND_CLEAR_DONE;
                  sidx_in   = '0;
                  last_in   = 1'b1;
               end
            endcase
         end
      end else begin
         idx_in = idx_ff + IDX_W'(1);
         if (end_step) begin
            // token has left the row
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            kind_in   = set_ff ? KIND_NO_SPACE : KIND_TICK_DONE;
            sidx_in   = '0;
            last_in   = 1'b1;
         end else if (cell_hit) begin
            strobe_in = 1'b1;
            kind_in   = set_ff ? KIND_SET_OK : KIND_FIRED;
            sidx_in   = SLOT_W'(idx_ff);
            last_in   = set_ff;
            if (set_ff) begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload flops
   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      set_ff  <= set_in;
      ivl_ff  <= ivl_in;
      kind_ff <= kind_in;
      sidx_ff <= sidx_in;
      last_ff <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_slot_index = sidx_ff;
   assign rsp_last       = last_ff;

endmodule
